[rtl/zero_crossing_frequency_averager_defines.svh]
// Assertion macros for the zero-crossing frequency averager checker.
// Both expect i_clk and i_rst_n in scope.
`ifndef ZERO_CROSSING_FREQUENCY_AVERAGER_DEFINES_SVH
`define ZERO_CROSSING_FREQUENCY_AVERAGER_DEFINES_SVH

// Same-cycle implication.
`define ZCFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ZCFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/zcfa_pkg.sv]
package zcfa_pkg;

    localparam int TIME_WIDTH      = 46;
    localparam int COUNT_WIDTH     = 16;
    localparam int REF_WIDTH       = 31;
    localparam int RECIP_WIDTH     = 32;
    localparam int DEV_WIDTH       = 32;
    localparam int PAIR_WIDTH      = TIME_WIDTH + 1;
    localparam int SUM_WIDTH       = PAIR_WIDTH + COUNT_WIDTH;
    localparam int FSUM_WIDTH      = RECIP_WIDTH + COUNT_WIDTH;
    localparam int DIV_WIDTH       = (SUM_WIDTH > FSUM_WIDTH) ? SUM_WIDTH : FSUM_WIDTH;
    localparam int DVS_WIDTH       = TIME_WIDTH;
    localparam int ITER_WIDTH      = $clog2(DIV_WIDTH + 1);
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [COUNT_WIDTH-1:0] WINDOW_LEN_RESET = COUNT_WIDTH'(1000);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_LEN     = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REFERENCE_FREQ = CFG_INDEX_WIDTH'(1);

    // 2^31, also the saturated value for a zero interval
    localparam logic [RECIP_WIDTH-1:0] RECIP_SAT = {1'b1, {(RECIP_WIDTH-1){1'b0}}};

    // 2^31 left-aligned for a RECIP_WIDTH-step division
    localparam logic [DIV_WIDTH-1:0] RECIP_DIVIDEND = {1'b1, {(DIV_WIDTH-1){1'b0}}};

    localparam logic [DEV_WIDTH-1:0] DEV_MAX = {1'b0, {(DEV_WIDTH-1){1'b1}}};
    localparam logic [DEV_WIDTH-1:0] DEV_MIN = {1'b1, {(DEV_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [TIME_WIDTH-1:0] crossing_time;
        logic                  first_of_run;
    } t_in_item;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]       mean_time;
        logic signed [DEV_WIDTH-1:0] freq_deviation;
        logic                        zero_interval_seen;
    } t_out_item;

    // dividend is left-aligned: value << (DIV_WIDTH - iters)
    typedef struct packed {
        logic                  start;
        logic [DIV_WIDTH-1:0]  dividend;
        logic [DVS_WIDTH-1:0]  divisor;
        logic [ITER_WIDTH-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_WIDTH-1:0] quotient;
    } t_div_rsp;

endpackage

[rtl/zero_crossing_frequency_averager.sv]
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_ready  i_in  (t_in_item)
// out       output     o_out_valid / i_out_ready o_out (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A start-of-run transaction only stores its crossing time and clears the window
// sums. Other transactions run a 32-step division on the shared restoring divider
// (skipped for a zero interval). A transaction that closes a window adds a 63-step
// and a 48-step division on the same divider, plus the output load.
// Input is taken only in the idle state, not while divisions or the output load run.
// Synchronous active-low reset; no clearing pass.
module zero_crossing_frequency_averager import zcfa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  t_in_item                   i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_out_item                  o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RECIP,
        S_RECIP_WAIT,
        S_ACCUM,
        S_CHECK,
        S_MEAN_T_WAIT,
        S_MEAN_F,
        S_MEAN_F_WAIT,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [COUNT_WIDTH-1:0]  r_window_len;
    logic [REF_WIDTH-1:0]    r_ref;
    logic                    r_have_prev;
    logic [TIME_WIDTH-1:0]   r_prev;
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [SUM_WIDTH-1:0]    r_mid_sum;
    logic [FSUM_WIDTH-1:0]   r_freq_sum;
    logic                    r_zero;
    logic [PAIR_WIDTH-1:0]   r_pair_sum;
    logic [TIME_WIDTH-1:0]   r_dt;
    logic [RECIP_WIDTH-1:0]  r_recip;
    logic [TIME_WIDTH-1:0]   r_mean_t;
    logic [RECIP_WIDTH-1:0]  r_mean_f;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [COUNT_WIDTH-1:0]  w_wl;
    logic                    w_emit;
    logic [DEV_WIDTH:0]      w_dev;
    logic [DEV_WIDTH-1:0]    w_dev_sat;
    t_div_req                w_req;
    t_div_rsp                w_rsp;

    assign w_wl   = (r_window_len == '0) ? COUNT_WIDTH'(1) : r_window_len;
    assign w_emit = (r_count >= w_wl);

    assign w_dev = (DEV_WIDTH + 1)'(r_mean_f) - (DEV_WIDTH + 1)'(r_ref);

    always_comb begin
        if (!w_dev[DEV_WIDTH] && w_dev[DEV_WIDTH-1]) begin
            w_dev_sat = DEV_MAX;
        end else if (w_dev[DEV_WIDTH] && !w_dev[DEV_WIDTH-1]) begin
            w_dev_sat = DEV_MIN;
        end else begin
            w_dev_sat = w_dev[DEV_WIDTH-1:0];
        end
    end

    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_RECIP: begin
                w_req.start    = (r_dt != '0);
                w_req.dividend = RECIP_DIVIDEND;
                w_req.divisor  = r_dt;
                w_req.iters    = ITER_WIDTH'(RECIP_WIDTH);
            end
            S_CHECK: begin
                w_req.start    = w_emit;
                w_req.dividend = DIV_WIDTH'(r_mid_sum) << (DIV_WIDTH - SUM_WIDTH);
                w_req.divisor  = DVS_WIDTH'(r_count);
                w_req.iters    = ITER_WIDTH'(SUM_WIDTH);
            end
            S_MEAN_F: begin
                w_req.start    = 1'b1;
                w_req.dividend = DIV_WIDTH'(r_freq_sum) << (DIV_WIDTH - FSUM_WIDTH);
                w_req.divisor  = DVS_WIDTH'(r_count);
                w_req.iters    = ITER_WIDTH'(FSUM_WIDTH);
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    zcfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window_len <= WINDOW_LEN_RESET;
            r_ref        <= '0;
            r_have_prev  <= 1'b0;
            r_prev       <= '0;
            r_count      <= '0;
            r_mid_sum    <= '0;
            r_freq_sum   <= '0;
            r_zero       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WINDOW_LEN:     r_window_len <= i_cfg_data[COUNT_WIDTH-1:0];
                    CFG_REFERENCE_FREQ: r_ref        <= i_cfg_data[REF_WIDTH-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_prev <= i_in.crossing_time;
                        if (i_in.first_of_run || !r_have_prev) begin
                            r_have_prev <= 1'b1;
                            r_count     <= '0;
                            r_mid_sum   <= '0;
                            r_freq_sum  <= '0;
                            r_zero      <= 1'b0;
                        end else begin
                            r_pair_sum <= PAIR_WIDTH'(r_prev) + PAIR_WIDTH'(i_in.crossing_time);
                            r_dt       <= i_in.crossing_time - r_prev;
                            r_state    <= S_RECIP;
                        end
                    end
                end
                S_RECIP: begin
                    r_mid_sum <= r_mid_sum + SUM_WIDTH'(r_pair_sum);
                    if (r_dt == '0) begin
                        r_recip <= RECIP_SAT;
                        r_zero  <= 1'b1;
                        r_state <= S_ACCUM;
                    end else begin
                        r_state <= S_RECIP_WAIT;
                    end
                end
                S_RECIP_WAIT: begin
                    if (w_rsp.done) begin
                        r_recip <= w_rsp.quotient[RECIP_WIDTH-1:0];
                        r_state <= S_ACCUM;
                    end
                end
                S_ACCUM: begin
                    r_freq_sum <= r_freq_sum + FSUM_WIDTH'(r_recip);
                    r_count    <= r_count + COUNT_WIDTH'(1);
                    r_state    <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= w_emit ? S_MEAN_T_WAIT : S_IDLE;
                end
                S_MEAN_T_WAIT: begin
                    if (w_rsp.done) begin
                        // sum holds t1 + t2, so halve the quotient
                        r_mean_t <= w_rsp.quotient[TIME_WIDTH:1];
                        r_state  <= S_MEAN_F;
                    end
                end
                S_MEAN_F: begin
                    r_state <= S_MEAN_F_WAIT;
                end
                S_MEAN_F_WAIT: begin
                    if (w_rsp.done) begin
                        r_mean_f <= w_rsp.quotient[RECIP_WIDTH-1:0];
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid              <= 1'b1;
                        r_out.mean_time          <= r_mean_t;
                        r_out.freq_deviation     <= w_dev_sat;
                        r_out.zero_interval_seen <= r_zero;
                        r_count                  <= '0;
                        r_mid_sum                <= '0;
                        r_freq_sum               <= '0;
                        r_zero                   <= 1'b0;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[rtl/zcfa_div.sv]
module zcfa_div import zcfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [ITER_WIDTH-1:0] r_count;
    logic [DIV_WIDTH-1:0]  r_quo;
    logic [DVS_WIDTH-1:0]  r_rem;
    logic [DVS_WIDTH-1:0]  r_dvs;

    logic [DVS_WIDTH:0] w_shift;
    logic [DVS_WIDTH:0] w_diff;
    logic               w_take;

    assign w_shift = {r_rem, r_quo[DIV_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_take  = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= i_req.iters;
                r_quo   <= i_req.dividend;
                r_rem   <= '0;
                r_dvs   <= i_req.divisor;
            end else if (r_busy) begin
                r_quo   <= {r_quo[DIV_WIDTH-2:0], w_take};
                r_rem   <= w_take ? w_diff[DVS_WIDTH-1:0] : w_shift[DVS_WIDTH-1:0];
                r_count <= r_count - ITER_WIDTH'(1);
                if (r_count == ITER_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[rtl/zcfa_checker.sv]
`include "zero_crossing_frequency_averager_defines.svh"

module zcfa_checker import zcfa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // stalled result holds
    `ZCFA_ASSERT_NEXT(a_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stall")

    // an input transaction never yields a result in the next cycle
    `ZCFA_ASSERT_NEXT(a_no_fast, i_in_valid && o_in_ready && !o_out_valid, !o_out_valid, "early")

    // mean frequency is never below -(2^31 - 1) after the reference
    `ZCFA_ASSERT_SAME(a_dev_range, o_out_valid, o_out.freq_deviation != DEV_MIN, "dev range")

endmodule

bind zero_crossing_frequency_averager zcfa_checker u_zcfa_checker (.*);
